>>> hw/rtl/graph_segment_edge_merge_unit_macros.svh
// Assertion helpers for the edge merge unit.
`ifndef GRAPH_SEGMENT_EDGE_MERGE_UNIT_MACROS_SVH
`define GRAPH_SEGMENT_EDGE_MERGE_UNIT_MACROS_SVH

// Implication checked on every edge while out of reset.
`define GSEM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked while out of reset.
`define GSEM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/gsem_pkg.sv
package gsem_pkg;

    localparam int unsigned NodeW  = 16;
    localparam int unsigned SizeW  = 17;
    localparam int unsigned WtW    = 16;
    localparam int unsigned CfgW   = 16;
    localparam int unsigned ThrW   = 25;

    localparam logic [1:0] OUT_SAME   = 2'd0;
    localparam logic [1:0] OUT_MERGED = 2'd1;
    localparam logic [1:0] OUT_REJECT = 2'd2;
    localparam logic [1:0] OUT_QUERY  = 2'd3;

    localparam logic REQ_EDGE  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [CfgW-1:0] MergeConstantReset = 16'd300;

    typedef struct packed {
        logic            req_type;
        logic [NodeW-1:0] node_a;
        logic [NodeW-1:0] node_b;
        logic [WtW-1:0]   weight;
    } t_req;

    typedef struct packed {
        logic [1:0]       outcome;
        logic [NodeW-1:0] root;
        logic [SizeW-1:0] comp_size;
        logic [WtW-1:0]   largest_weight;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIND_A,
        ST_FIND_B,
        ST_DIV_A,
        ST_DIV_B,
        ST_DECIDE,
        ST_WRITE
    } t_state;

    // Divider handshake.
    typedef struct packed {
        logic            start;
        logic [CfgW-1:0] dividend;
        logic [SizeW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [CfgW-1:0] quotient;
    } t_div_rsp;

endpackage

>>> hw/rtl/gsem_divider.sv
// Restoring divider, one quotient bit per cycle. Divisor zero gives zero.
module gsem_divider
    import gsem_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int unsigned CntW = $clog2(CfgW + 1);

    logic [SizeW-1:0] r_rem, n_rem;
    logic [CfgW-1:0]  r_quo, n_quo;
    logic [SizeW-1:0] r_den;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [SizeW:0]   w_trial;

    always_comb begin
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem, r_quo[CfgW-1]} - {1'b0, r_den};
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_cnt  = CntW'(CfgW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[SizeW]) begin
                n_rem = w_trial[SizeW-1:0];
                n_quo = {r_quo[CfgW-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[SizeW-2:0], r_quo[CfgW-1]};
                n_quo = {r_quo[CfgW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_req.start) r_den <= i_req.divisor;
    end

    always_comb begin
        o_rsp.done     = r_done;
        o_rsp.quotient = (r_den == '0) ? '0 : r_quo;
    end
endmodule

>>> hw/rtl/graph_segment_edge_merge_unit.sv
// Edge merge stage of graph segmentation: a union-find forest kept in one
// on-chip memory of NODES words {parent, size, largest weight}. One item is
// worked at a time; busy is high from the accepting edge until the end of the
// result strobe cycle. After reset a clearing pass writes every entry, with
// busy held high; configuration writes are taken throughout. An edge costs
// two root walks and a query one, each visited node taking one read and one
// registered response; then, for an edge between two different roots, two
// slack divisions of 16 quotient steps each, then one write for each changed
// root. The receiver cannot stall: o_valid marks the one cycle on which the
// result stands on o_rsp.
`include "graph_segment_edge_merge_unit_macros.svh"
module graph_segment_edge_merge_unit
    import gsem_pkg::*;
#(
    parameter int unsigned NODES = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  t_req            i_req,
    output logic            o_valid,
    output t_rsp            o_rsp,
    input  logic            i_cfg_we,
    input  logic [CfgW-1:0] i_cfg_data
);
    localparam int unsigned AW = (NODES > 1) ? $clog2(NODES) : 1;

    typedef struct packed {
        logic [AW-1:0]    par;
        logic [SizeW-1:0] size;
        logic [WtW-1:0]   mx;
    } t_entry;

    // Forest memory: single write port, one read port, registered read.
    t_entry r_mem [NODES];
    t_entry r_rd;
    logic [AW-1:0] w_raddr, w_waddr;
    logic          w_re, w_we;
    t_entry        w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (w_re) r_rd <= r_mem[w_raddr];
    end

    // Index reduction modulo NODES. Power of two: a mask. Otherwise a
    // reciprocal multiply whose quotient is at most one short, then one
    // compare-subtract.
    localparam logic [31:0] IdxRecip = 32'((64'd1 << 32) / 64'(NODES));

    function automatic logic [AW-1:0] f_idx(input logic [NodeW-1:0] v);
        logic [NodeW+31:0] p;
        logic [NodeW-1:0]  q;
        logic [47:0]       t;
        t = 48'(v);
        if ((NODES & (NODES - 1)) == 0) return t[AW-1:0];
        p = (NodeW+32)'(v) * (NodeW+32)'(IdxRecip);
        q = p[NodeW+31:32];
        t = 48'(v) - 48'(q) * 48'(NODES);
        if (t >= 48'(NODES)) t = t - 48'(NODES);
        return t[AW-1:0];
    endfunction

    logic [CfgW-1:0] r_k;
    t_state  r_st, n_st;
    t_req    r_q;
    logic [AW-1:0] r_cur, n_cur;
    logic    r_pend, n_pend;
    logic [AW-1:0] r_ra, n_ra, r_rb, n_rb;
    t_entry  r_ea, n_ea, r_eb, n_eb;
    logic [CfgW-1:0] r_sa, n_sa;
    logic    r_wr2, n_wr2;
    logic    r_val, n_val;
    t_rsp    r_rsp, n_rsp;
    logic [AW:0] r_clr, n_clr;

    t_div_req w_dreq;
    t_div_rsp w_drsp;
    gsem_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    logic [ThrW-1:0] w_ta, w_tb;
    logic [SizeW:0]  w_sum;
    logic            w_keep_a;
    logic [WtW-1:0]  w_m;

    always_comb begin
        w_ta     = ThrW'(r_ea.mx) + ThrW'({r_sa, 8'd0});
        w_tb     = ThrW'(r_eb.mx) + ThrW'({w_drsp.quotient, 8'd0});
        w_sum    = (SizeW+1)'(r_ea.size) + (SizeW+1)'(r_eb.size);
        w_keep_a = r_ea.size >= r_eb.size;
        w_m      = (r_ea.mx > r_eb.mx) ? r_ea.mx : r_eb.mx;
        if (r_q.weight > w_m) w_m = r_q.weight;
    end

    always_comb begin
        n_st   = r_st;
        n_cur  = r_cur;
        n_pend = 1'b0;
        n_ra   = r_ra;
        n_rb   = r_rb;
        n_ea   = r_ea;
        n_eb   = r_eb;
        n_sa   = r_sa;
        n_wr2  = r_wr2;
        n_val  = 1'b0;
        n_rsp  = r_rsp;
        n_clr  = r_clr;
        w_re   = 1'b0;
        w_raddr = r_cur;
        w_we   = 1'b0;
        w_waddr = r_clr[AW-1:0];
        w_wdata = '{par: r_clr[AW-1:0], size: SizeW'(1), mx: '0};
        w_dreq = '{start: 1'b0, dividend: r_k, divisor: r_ea.size};
        case (r_st)
            ST_CLEAR: begin
                w_we  = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == (AW+1)'(NODES - 1)) n_st = ST_IDLE;
            end
            ST_IDLE: begin
                // No accept while the previous result is on the strobe.
                if (start && !r_val) begin
                    n_cur  = f_idx(i_req.node_a);
                    n_pend = 1'b0;
                    n_st   = ST_FIND_A;
                end
            end
            ST_FIND_A, ST_FIND_B: begin
                // Alternate: issue read of r_cur, then inspect response.
                if (!r_pend) begin
                    w_re   = 1'b1;
                    n_pend = 1'b1;
                end else if (r_rd.par != r_cur) begin
                    n_cur = r_rd.par;
                end else if (r_st == ST_FIND_A) begin
                    n_ra = r_cur;
                    n_ea = r_rd;
                    if (r_q.req_type == REQ_QUERY) begin
                        n_val = 1'b1;
                        n_rsp = '{outcome: OUT_QUERY, root: NodeW'(r_cur),
                                  comp_size: r_rd.size, largest_weight: r_rd.mx};
                        n_st  = ST_IDLE;
                    end else begin
                        n_cur = f_idx(r_q.node_b);
                        n_st  = ST_FIND_B;
                    end
                end else begin
                    n_rb = r_cur;
                    n_eb = r_rd;
                    if (r_cur == r_ra) begin
                        n_val = 1'b1;
                        n_rsp = '{outcome: OUT_SAME, root: NodeW'(r_ra),
                                  comp_size: r_ea.size, largest_weight: r_ea.mx};
                        n_st  = ST_IDLE;
                    end else begin
                        w_dreq.start = 1'b1;
                        n_st = ST_DIV_A;
                    end
                end
            end
            ST_DIV_A: begin
                if (w_drsp.done) begin
                    n_sa = w_drsp.quotient;
                    w_dreq = '{start: 1'b1, dividend: r_k, divisor: r_eb.size};
                    n_st = ST_DIV_B;
                end
            end
            ST_DIV_B: begin
                if (w_drsp.done) begin
                    if ((ThrW'(r_q.weight) > w_ta) || (ThrW'(r_q.weight) > w_tb)) begin
                        n_val = 1'b1;
                        n_rsp = '{outcome: OUT_REJECT, root: NodeW'(r_ra),
                                  comp_size: r_ea.size, largest_weight: r_ea.mx};
                        n_st  = ST_IDLE;
                    end else begin
                        n_st = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                // Write keep root with merged size and weight.
                w_we    = 1'b1;
                w_waddr = w_keep_a ? r_ra : r_rb;
                w_wdata = '{par: w_keep_a ? r_ra : r_rb, size: w_sum[SizeW-1:0], mx: w_m};
                n_st    = ST_WRITE;
                n_wr2   = w_keep_a;
                n_rsp   = '{outcome: OUT_MERGED, root: NodeW'(w_keep_a ? r_ra : r_rb),
                            comp_size: w_sum[SizeW-1:0], largest_weight: w_m};
            end
            ST_WRITE: begin
                // Repoint the absorbed root.
                w_we    = 1'b1;
                w_waddr = r_wr2 ? r_rb : r_ra;
                w_wdata = r_wr2 ? r_eb : r_ea;
                w_wdata.par = r_wr2 ? r_ra : r_rb;
                n_val   = 1'b1;
                n_st    = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_CLEAR;
            r_clr  <= '0;
            r_pend <= 1'b0;
            r_val  <= 1'b0;
            r_k    <= MergeConstantReset;
        end else begin
            r_st   <= n_st;
            r_clr  <= n_clr;
            r_pend <= n_pend;
            r_val  <= n_val;
            if (i_cfg_we) r_k <= i_cfg_data;
        end
        if (r_st == ST_IDLE && start && !r_val) r_q <= i_req;
        r_cur <= n_cur;
        r_ra  <= n_ra;
        r_rb  <= n_rb;
        r_ea  <= n_ea;
        r_eb  <= n_eb;
        r_sa  <= n_sa;
        r_wr2 <= n_wr2;
        r_rsp <= n_rsp;
    end

    assign busy    = (r_st != ST_IDLE) || r_val;
    assign o_valid = r_val;
    assign o_rsp   = r_rsp;

    `GSEM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy,
        "busy not raised after accept")
    `GSEM_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, r_st == ST_IDLE,
        "result strobe outside idle")
    `GSEM_ASSERT_NXT(a_write_done, i_clk, i_rst_n, r_st == ST_WRITE,
        o_valid && o_rsp.outcome == OUT_MERGED, "merge write without result")
    `GSEM_ASSERT_IMP(a_merge_size, i_clk, i_rst_n,
        o_valid && o_rsp.outcome == OUT_MERGED, o_rsp.comp_size >= SizeW'(2),
        "merged component too small")
endmodule

>>> bench/graph_segment_edge_merge_unit_tb.sv
module graph_segment_edge_merge_unit_tb;
    import gsem_pkg::*;

    localparam int unsigned NodeCount = 65536;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    t_req            i_req = '0;
    logic            o_valid;
    t_rsp            o_rsp;
    logic            i_cfg_we = 1'b0;
    logic [CfgW-1:0] i_cfg_data = '0;

    graph_segment_edge_merge_unit #(.NODES(NodeCount)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow union-find forest, kept in step with every accepted item.
    logic [NodeW-1:0] fw_parent [NodeCount];
    logic [SizeW-1:0] fw_size   [NodeCount];
    logic [WtW-1:0]   fw_maxwt  [NodeCount];
    logic [CfgW-1:0]  merge_k;

    t_req pending_items [$];   // items not yet handed to the block
    t_rsp expected_rsps [$];   // predicted results, oldest first
    bit   failed = 1'b0;

    // Driver state.
    int   gap_left = 0;
    bit   no_idle  = 1'b0;
    logic start_nxt;

    function automatic logic [NodeW-1:0] root_of(logic [NodeW-1:0] n);
        logic [NodeW-1:0] r;
        logic [NodeW-1:0] nx;
        r = n;
        while (fw_parent[r] != r) r = fw_parent[r];
        // path compression; answers unchanged
        while (fw_parent[n] != r) begin
            nx = fw_parent[n];
            fw_parent[n] = r;
            n = nx;
        end
        return r;
    endfunction

    function automatic logic [ThrW-1:0] merge_limit(logic [NodeW-1:0] r);
        logic [ThrW-1:0] slack;
        slack = ThrW'(merge_k / fw_size[r]);
        return ThrW'(fw_maxwt[r]) + (slack << 8);
    endfunction

    function automatic t_rsp report(logic [1:0] oc, logic [NodeW-1:0] r);
        t_rsp p;
        p.outcome        = oc;
        p.root           = r;
        p.comp_size      = fw_size[r];
        p.largest_weight = fw_maxwt[r];
        return p;
    endfunction

    // Apply one item to the shadow forest and return the result it causes.
    function automatic t_rsp merge_step(t_req q);
        logic [NodeW-1:0] ra, rb, keep, gone;
        logic [WtW-1:0]   m;
        ra = root_of(q.node_a);
        if (q.req_type == REQ_QUERY) return report(OUT_QUERY, ra);
        rb = root_of(q.node_b);
        if (ra == rb) return report(OUT_SAME, ra);
        if (ThrW'(q.weight) > merge_limit(ra) || ThrW'(q.weight) > merge_limit(rb))
            return report(OUT_REJECT, ra);
        // larger side keeps its root; node_a's side wins ties
        if (fw_size[ra] >= fw_size[rb]) begin
            keep = ra; gone = rb;
        end else begin
            keep = rb; gone = ra;
        end
        m = (fw_maxwt[ra] > fw_maxwt[rb]) ? fw_maxwt[ra] : fw_maxwt[rb];
        if (q.weight > m) m = q.weight;
        fw_parent[gone] = keep;
        fw_size[keep]   = fw_size[ra] + fw_size[rb];
        fw_maxwt[keep]  = m;
        return report(OUT_MERGED, keep);
    endfunction

    // Driver: predict on the accepting edge, then launch the next item after
    // a drawn gap. Bursts with no gap are mixed in.
    always @(posedge i_clk) begin
        start_nxt = start;
        if (i_rst_n && start && !busy) begin
            expected_rsps = {expected_rsps, merge_step(i_req)};
            start_nxt = 1'b0;
            if ($urandom_range(0, 15) == 0) no_idle = ~no_idle;
            gap_left = no_idle ? 0 : $urandom_range(0, 10);
        end
        if (i_rst_n && !start_nxt && pending_items.size() > 0) begin
            if (gap_left > 0) begin
                gap_left--;
            end else begin
                i_req <= pending_items.pop_front();
                start_nxt = 1'b1;
            end
        end
        start <= start_nxt;
    end

    // Monitor: every strobed result against the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid) begin
            if (expected_rsps.size() == 0) begin
                $error("result with no item outstanding: %h", o_rsp);
                failed = 1'b1;
            end else begin
                want = expected_rsps.pop_front();
                if (o_rsp.outcome !== want.outcome) begin
                    $error("outcome: expected %0d, got %0d", want.outcome, o_rsp.outcome);
                    failed = 1'b1;
                end
                if (o_rsp.root !== want.root) begin
                    $error("root: expected %0d, got %0d", want.root, o_rsp.root);
                    failed = 1'b1;
                end
                if (o_rsp.comp_size !== want.comp_size) begin
                    $error("comp_size: expected %0d, got %0d",
                           want.comp_size, o_rsp.comp_size);
                    failed = 1'b1;
                end
                if (o_rsp.largest_weight !== want.largest_weight) begin
                    $error("largest_weight: expected %0d, got %0d",
                           want.largest_weight, o_rsp.largest_weight);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic add_item(logic typ, logic [15:0] a, logic [15:0] b, logic [15:0] w);
        t_req q;
        q.req_type = typ;
        q.node_a   = a;
        q.node_b   = b;
        q.weight   = w;
        pending_items = {pending_items, q};
    endtask

    // Sender holds off until the block has answered everything.
    task automatic drain();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || start || expected_rsps.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_k(logic [CfgW-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        merge_k = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sorted edges inside a small window of nodes, so merges chain into
    // real components; queries, out-of-order edges and noise mixed in.
    task automatic add_segment_run(int count);
        logic [15:0] base, wt, a;
        int          span, sel;
        base = 16'($urandom);
        span = $urandom_range(4, 64);
        wt   = 16'($urandom_range(0, 512));
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            a   = 16'(base + $urandom_range(0, span));
            if (sel < 20) begin
                add_item(REQ_QUERY, a, 16'($urandom), 16'($urandom));
            end else if (sel < 28) begin
                add_item(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                         16'($urandom));
            end else if (sel < 33) begin
                add_item(REQ_EDGE, a, 16'(base + $urandom_range(0, span)),
                         16'($urandom));
            end else begin
                wt = (wt > 16'hffff - 300) ? wt : 16'(wt + $urandom_range(0, 300));
                add_item(REQ_EDGE, a, 16'(base + $urandom_range(0, span)), wt);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NodeCount; i++) begin
            fw_parent[i] = NodeW'(i);
            fw_size[i]   = SizeW'(1);
            fw_maxwt[i]  = '0;
        end
        merge_k = MergeConstantReset;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset constant, extremes of node indexes and weights,
        // self edge, equal-size and unequal-size merges, rejections.
        add_item(REQ_QUERY, 16'd0, 16'hffff, 16'hffff);
        add_item(REQ_QUERY, 16'hffff, 16'd0, 16'd0);
        add_item(REQ_EDGE, 16'd5, 16'd5, 16'd0);
        add_item(REQ_EDGE, 16'd0, 16'hffff, 16'd0);
        add_item(REQ_EDGE, 16'd1, 16'hffff, 16'd100);
        add_item(REQ_EDGE, 16'd2, 16'd3, 16'd200);
        add_item(REQ_EDGE, 16'd2, 16'd1, 16'd300);
        add_item(REQ_EDGE, 16'd0, 16'd3, 16'd400);
        add_item(REQ_QUERY, 16'd3, 16'd0, 16'd0);
        add_item(REQ_EDGE, 16'd10, 16'd11, 16'hffff);
        add_item(REQ_EDGE, 16'd12, 16'd13, 16'd11264);
        add_item(REQ_EDGE, 16'd12, 16'd0, 16'hffff);
        add_item(REQ_EDGE, 16'd14, 16'd13, 16'd50);
        add_item(REQ_QUERY, 16'd14, 16'h5555, 16'haaaa);
        drain();
        write_k(16'd0);
        add_item(REQ_EDGE, 16'd20, 16'd21, 16'd0);
        add_item(REQ_EDGE, 16'd22, 16'd23, 16'd1);
        add_item(REQ_EDGE, 16'd20, 16'd22, 16'd0);
        add_item(REQ_EDGE, 16'haaaa, 16'h5555, 16'd0);
        add_item(REQ_QUERY, 16'h5555, 16'd0, 16'd0);
        drain();
        write_k(16'hffff);
        add_item(REQ_EDGE, 16'd30, 16'd31, 16'hffff);
        add_item(REQ_EDGE, 16'd30, 16'd32, 16'h8000);
        add_item(REQ_QUERY, 16'd32, 16'd0, 16'd0);
        drain();

        // Random phases, each under a constant written at its start.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_k(16'd300);
                1: write_k(16'd0);
                2: write_k(16'hffff);
                3: write_k(16'd1);
                default: write_k(CfgW'($urandom));
            endcase
            for (int r = 0; r < 4; r++) add_segment_run($urandom_range(40, 80));
            drain();
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (!failed) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Timeout covering the clearing pass plus roughly 1450 items.
    initial begin
        #10000000;
        $display("FAILURE");
        $finish;
    end

endmodule
